[rtl/hrst_pkg.sv]
// ----------------------------------------------------------------------------
// hrst_pkg
// Shared types and constants of the hash ring successor table: command and
// status codes, the request and response payloads, and the control groups
// that run between the control, scan and memory parts.
// ----------------------------------------------------------------------------
package hrst_pkg;

   localparam int MAX_NODES   = 16;
   localparam int INDEX_WIDTH = $clog2(MAX_NODES);
   localparam int COUNT_WIDTH = INDEX_WIDTH + 1;
   localparam int POS_WIDTH   = 16;
   localparam int OUT_INDEX_WIDTH = 4;

   typedef logic [POS_WIDTH-1:0]       pos_type;
   typedef logic [INDEX_WIDTH-1:0]     index_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [OUT_INDEX_WIDTH-1:0] out_index_type;

   localparam count_type TABLE_FULL_COUNT = COUNT_WIDTH'(MAX_NODES);

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_NO_ADD = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type cmd;
      pos_type key_position;
      pos_type node_position;
   } req_type;

   typedef struct packed {
      out_index_type owner_index;
      out_index_type new_index;
      logic          moves;
      status_type    status;
   } rsp_type;

   typedef struct packed {
      logic      start;
      pos_type   pos;
      count_type count;
   } scan_req_type;

   typedef struct packed {
      logic      done;
      index_type index;
      pos_type   value;
   } scan_rsp_type;

   typedef struct packed {
      logic      en;
      index_type addr;
      pos_type   data;
   } mem_wr_type;

   typedef struct packed {
      logic      en;
      index_type addr;
   } mem_rd_type;

endpackage

[rtl/hrst_pos_ram.sv]
// ----------------------------------------------------------------------------
// hrst_pos_ram
// Node position store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hrst_pos_ram
   import hrst_pkg::*;
(
   input  logic       clock,
   input  mem_wr_type wr,
   input  mem_rd_type rd,
   output pos_type    rd_data
);

   pos_type mem [MAX_NODES];
   pos_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hrst_succ_scan.sv]
// ----------------------------------------------------------------------------
// hrst_succ_scan
// Successor search: walks entries 0 to count-1 through the memory read port,
// one entry per cycle, and keeps the first smallest position at or above the
// search position, plus the first overall minimum for the wrap case.
// ----------------------------------------------------------------------------
module hrst_succ_scan
   import hrst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  scan_req_type scan_req,
   output scan_rsp_type scan_rsp,
   output mem_rd_type   rd,
   input  pos_type      rd_data
);

   count_type issue_idx_ff, issue_idx_in;
   logic      issuing_ff, issuing_in;
   logic      data_vld_ff, data_vld_in;
   logic      data_last_ff, data_last_in;
   index_type data_idx_ff, data_idx_in;
   pos_type   pos_ff, pos_in;
   logic      found_ff, found_in;
   index_type best_ff, best_in;
   pos_type   best_val_ff, best_val_in;
   index_type lowest_ff, lowest_in;
   pos_type   lowest_val_ff, lowest_val_in;
   logic      done_ff, done_in;
   index_type res_idx_ff, res_idx_in;
   pos_type   res_val_ff, res_val_in;
   count_type last_idx;
   logic      issue_last;

   always_comb begin
      last_idx   = scan_req.count - COUNT_WIDTH'(1);
      issue_last = issuing_ff && (issue_idx_ff == last_idx);

      rd.en   = issuing_ff;
      rd.addr = issue_idx_ff[INDEX_WIDTH-1:0];

      issue_idx_in = issue_idx_ff;
      issuing_in   = issuing_ff;
      pos_in       = pos_ff;
      if (scan_req.start) begin
         issue_idx_in = '0;
         issuing_in   = 1'b1;
         pos_in       = scan_req.pos;
      end else if (issuing_ff) begin
         issue_idx_in = issue_idx_ff + COUNT_WIDTH'(1);
         if (issue_last) begin
            issuing_in = 1'b0;
         end
      end

      data_vld_in  = issuing_ff;
      data_last_in = issue_last;
      data_idx_in  = issue_idx_ff[INDEX_WIDTH-1:0];

      found_in      = scan_req.start ? 1'b0 : found_ff;
      best_in       = best_ff;
      best_val_in   = best_val_ff;
      lowest_in     = lowest_ff;
      lowest_val_in = lowest_val_ff;
      if (data_vld_ff) begin
         if ((data_idx_ff == '0) || (rd_data < lowest_val_ff)) begin
            lowest_in     = data_idx_ff;
            lowest_val_in = rd_data;
         end
         if ((rd_data >= pos_ff) && (!found_ff || (rd_data < best_val_ff))) begin
            found_in    = 1'b1;
            best_in     = data_idx_ff;
            best_val_in = rd_data;
         end
      end

      done_in    = data_vld_ff && data_last_ff;
      res_idx_in = found_in ? best_in : lowest_in;
      res_val_in = found_in ? best_val_in : lowest_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         data_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         issuing_ff  <= issuing_in;
         data_vld_ff <= data_vld_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff  <= issue_idx_in;
      data_last_ff  <= data_last_in;
      data_idx_ff   <= data_idx_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_val_ff   <= best_val_in;
      lowest_ff     <= lowest_in;
      lowest_val_ff <= lowest_val_in;
      res_idx_ff    <= res_idx_in;
      res_val_ff    <= res_val_in;
   end

   assign scan_rsp.done  = done_ff;
   assign scan_rsp.index = res_idx_ff;
   assign scan_rsp.value = res_val_ff;

endmodule

[rtl/hash_ring_successor_table_unit.sv]
// ----------------------------------------------------------------------------
// hash_ring_successor_table_unit
// Successor table for a consistent-hashing ring: lookup, add and move check.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single response
// appears on rsp_data for exactly one cycle with rsp_valid high and cannot be
// held off. Move checks, unused commands, a lookup on an empty table and the
// first add give their response in the cycle after the transfer, and busy stays
// low so a new command may follow at once. A lookup or add on a non-empty
// table scans all stored entries through the single read port of the position
// memory, one entry per cycle; busy stays high while the scan runs and falls in
// the cycle in which the response appears. The table holds up to 16 entries.
module hash_ring_successor_table_unit
   import hrst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   pos_type      node_ff, node_in;
   count_type    count_ff, count_in;
   pos_type      last_new_ff, last_new_in;
   pos_type      last_succ_ff, last_succ_in;
   logic         add_seen_ff, add_seen_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   scan_req_type scan_req;
   scan_rsp_type scan_rsp;
   mem_wr_type   mem_wr;
   mem_rd_type   mem_rd;
   pos_type      mem_rd_data;
   logic         accept;
   logic         key_moves;

   hrst_pos_ram u_pos_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   hrst_succ_scan u_succ_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp),
      .rd       (mem_rd),
      .rd_data  (mem_rd_data)
   );

   always_comb begin
      accept = start && (state_ff == ST_IDLE);

      // Wrapping arc when the successor sits above the new node.
      if (last_succ_ff > last_new_ff) begin
         key_moves = (req_data.key_position > last_succ_ff) ||
                     (req_data.key_position <= last_new_ff);
      end else begin
         key_moves = (req_data.key_position > last_succ_ff) &&
                     (req_data.key_position <= last_new_ff);
      end

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      node_in      = node_ff;
      count_in     = count_ff;
      last_new_in  = last_new_ff;
      last_succ_in = last_succ_ff;
      add_seen_in  = add_seen_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      scan_req.start = 1'b0;
      scan_req.pos   = (req_data.cmd == CMD_ADD) ? req_data.node_position
                                                 : req_data.key_position;
      scan_req.count = count_ff;

      mem_wr.en   = 1'b0;
      mem_wr.addr = count_ff[INDEX_WIDTH-1:0];
      mem_wr.data = node_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_data.cmd;
               node_in = req_data.node_position;
               rsp_in  = '{owner_index: '0, new_index: '0, moves: 1'b0,
                           status: STATUS_OK};
               case (req_data.cmd)
                  CMD_LOOKUP, CMD_ADD: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                        if (req_data.cmd == CMD_ADD) begin
                           // First node is its own successor.
                           mem_wr.en    = 1'b1;
                           mem_wr.addr  = '0;
                           mem_wr.data  = req_data.node_position;
                           count_in     = COUNT_WIDTH'(1);
                           last_new_in  = req_data.node_position;
                           last_succ_in = req_data.node_position;
                           add_seen_in  = 1'b1;
                        end
                     end else begin
                        scan_req.start = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  CMD_CHECK: begin
                     rsp_valid_in = 1'b1;
                     if (!add_seen_ff) begin
                        rsp_in.status = STATUS_NO_ADD;
                     end else begin
                        rsp_in.moves = key_moves;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               state_in           = ST_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.owner_index = OUT_INDEX_WIDTH'(scan_rsp.index);
               if (cmd_ff == CMD_ADD) begin
                  if (count_ff >= TABLE_FULL_COUNT) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     // Append the node behind the last entry.
                     mem_wr.en        = 1'b1;
                     rsp_in.new_index = OUT_INDEX_WIDTH'(count_ff);
                     count_in         = count_ff + COUNT_WIDTH'(1);
                     last_new_in      = node_ff;
                     last_succ_in     = scan_rsp.value;
                     add_seen_in      = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_new_ff  <= '0;
         last_succ_ff <= '0;
         add_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_new_ff  <= last_new_in;
         last_succ_ff <= last_succ_in;
         add_seen_ff  <= add_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      node_ff <= node_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
